[design/lkc_pkg.sv]
// shared types and constants of the lru key cache
package lkc_pkg;

  localparam int KEY_W     = 32;
  localparam int CAP_W     = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef struct packed {
    logic             action;
    logic [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic             inserted;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic search;
    logic update;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

[design/lkc_ctrl.sv]
// controller state machine of the lru key cache
module lkc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  lkc_pkg::sts_t sts,
  output lkc_pkg::ctl_t ctl
);

  lkc_pkg::state_t state_r;
  lkc_pkg::state_t state_nxt;
  logic            take_in;

  // a new beat is taken when idle or while the previous item retires
  assign take_in = (state_r == lkc_pkg::ST_IDLE) ||
                   ((state_r == lkc_pkg::ST_UPDATE) && sts.out_free);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lkc_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = lkc_pkg::ST_SEARCH;
      end
      lkc_pkg::ST_SEARCH: begin
        state_nxt = lkc_pkg::ST_UPDATE;
      end
      lkc_pkg::ST_UPDATE: begin
        if (sts.out_free) begin
          state_nxt = in_valid ? lkc_pkg::ST_SEARCH : lkc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lkc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = !take_in;
    ctl.load_in = take_in && in_valid;
    ctl.search  = (state_r == lkc_pkg::ST_SEARCH);
    ctl.update  = (state_r == lkc_pkg::ST_UPDATE) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lkc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[design/lkc_datapath.sv]
// entry store, parallel match, recency ranks and result register
module lkc_datapath #(
  parameter int DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lkc_pkg::ctl_t             ctl,
  output lkc_pkg::sts_t             sts,
  input  lkc_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output lkc_pkg::out_item_t        out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [lkc_pkg::CAP_W-1:0] cfg_data
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = (CW > lkc_pkg::CAP_W) ? CW : lkc_pkg::CAP_W;

  logic [lkc_pkg::KEY_W-1:0] key_r   [DEPTH];
  logic [DEPTH-1:0]          valid_r;
  logic [DEPTH-1:0]          valid_nxt;
  logic [IW-1:0]             rank_r  [DEPTH];
  logic [IW-1:0]             rank_nxt[DEPTH];
  logic [CW-1:0]             count_r;
  logic [CW-1:0]             count_nxt;
  logic [lkc_pkg::CAP_W-1:0] cap_r;

  lkc_pkg::in_item_t         in_r;
  lkc_pkg::out_item_t        out_data_r;
  logic                      out_valid_r;
  logic                      out_valid_nxt;

  // search stage results
  logic [DEPTH-1:0]          match_r;
  logic [DEPTH-1:0]          slot_r;
  logic                      hit_r;
  logic [IW-1:0]             hit_rank_r;
  logic                      full_r;
  logic                      cap_nz_r;

  logic [DEPTH-1:0]          match_c;
  logic [DEPTH-1:0]          victim_c;
  logic [DEPTH-1:0]          free_c;
  logic [DEPTH-1:0]          first_free_c;
  logic [IW-1:0]             hit_rank_c;
  logic [IW-1:0]             lru_rank_c;
  logic [MW-1:0]             cap_eff_c;
  logic                      full_c;

  logic                      is_remove;
  logic                      ins;
  logic [lkc_pkg::KEY_W-1:0] evict_key_c;

  assign cfg_ready    = 1'b1;
  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

  // parallel compare against every entry
  always_comb begin
    hit_rank_c = '0;
    for (int i = 0; i < DEPTH; i++) begin
      match_c[i]  = valid_r[i] && (key_r[i] == in_r.key);
      victim_c[i] = valid_r[i] && (rank_r[i] == lru_rank_c);
      hit_rank_c  = hit_rank_c | (match_c[i] ? rank_r[i] : '0);
    end
  end

  // least recent entry holds rank count-1
  assign lru_rank_c   = IW'(count_r - CW'(1));
  assign free_c       = ~valid_r;
  assign first_free_c = free_c & (~free_c + {{(DEPTH-1){1'b0}}, 1'b1});
  assign cap_eff_c    = (MW'(cap_r) > MW'(DEPTH)) ? MW'(DEPTH) : MW'(cap_r);
  assign full_c       = MW'(count_r) >= cap_eff_c;

  always_ff @(posedge clk) begin
    if (ctl.search) begin
      match_r    <= match_c;
      hit_r      <= |match_c;
      hit_rank_r <= hit_rank_c;
      full_r     <= full_c;
      cap_nz_r   <= (cap_r != '0);
      slot_r     <= full_c ? victim_c : first_free_c;
    end
  end

  assign is_remove = (in_r.action == lkc_pkg::ACT_REMOVE);
  assign ins       = !is_remove && !hit_r && cap_nz_r;

  always_comb begin
    evict_key_c = '0;
    for (int i = 0; i < DEPTH; i++) begin
      evict_key_c = evict_key_c | (slot_r[i] ? key_r[i] : '0);
    end
  end

  // rank and valid updates, each entry on its own, and the entry count
  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    for (int i = 0; i < DEPTH; i++) begin
      rank_nxt[i] = rank_r[i];
    end
    if (ctl.update) begin
      priority if (is_remove && hit_r) begin
        count_nxt = count_r - CW'(1);
        for (int i = 0; i < DEPTH; i++) begin
          if (match_r[i]) begin
            valid_nxt[i] = 1'b0;
            rank_nxt[i]  = '0;
          end else if (valid_r[i] && (rank_r[i] > hit_rank_r)) begin
            rank_nxt[i] = rank_r[i] - IW'(1);
          end
        end
      end else if (!is_remove && hit_r) begin
        for (int i = 0; i < DEPTH; i++) begin
          if (match_r[i]) begin
            rank_nxt[i] = '0;
          end else if (valid_r[i] && (rank_r[i] < hit_rank_r)) begin
            rank_nxt[i] = rank_r[i] + IW'(1);
          end
        end
      end else if (ins) begin
        if (!full_r) count_nxt = count_r + CW'(1);
        for (int i = 0; i < DEPTH; i++) begin
          if (slot_r[i]) begin
            valid_nxt[i] = 1'b1;
            rank_nxt[i]  = '0;
          end else if (valid_r[i]) begin
            rank_nxt[i] = rank_r[i] + IW'(1);
          end
        end
      end else begin
        count_nxt = count_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      cap_r   <= lkc_pkg::CAP_RESET;
      for (int i = 0; i < DEPTH; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      if (cfg_valid && cfg_ready) cap_r <= cfg_data;
      for (int i = 0; i < DEPTH; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.update && ins) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (slot_r[i]) key_r[i] <= in_r.key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_in) in_r <= in_data;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (ctl.update) out_valid_nxt = 1'b1;
    else if (!out_stall)     out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.update) begin
      out_data_r.found       <= hit_r;
      out_data_r.inserted    <= ins;
      out_data_r.evicted     <= ins && full_r;
      out_data_r.evicted_key <= (ins && full_r) ? evict_key_c : '0;
    end
  end

endmodule

[design/lru_key_cache.sv]
// top level of the lru key cache
//
// fully associative key cache with least-recently-used replacement.
// input channel: in_valid / in_stall carry one beat of action and key.
// a lookup that hits makes the key most recent; a miss inserts it when the
// capacity is nonzero and evicts the least recent key once the cache is full.
// a remove drops the key and reports whether it was there.
// result channel: out_valid / out_stall carry one result beat per item.
// configuration: cfg_valid / cfg_ready write the capacity (reset value 16);
// cfg_ready is always high, writes belong to idle periods only.
// the input beat is registered, the parallel compare is registered in the
// search step, and the rank update writes the result register.
// a new item is taken only while the previous one retires in its update
// step, as the compare then update sequence shares the entry store.
// a stalled result is held in the output register; the item behind it waits
// in its update step and in_stall stays high until the result is taken.
// reset (rst_n low, synchronous) empties the cache, clears the ranks and the
// count, restores the capacity and drops any pending result.
module lru_key_cache #(
  parameter int DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  lkc_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output lkc_pkg::out_item_t        out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [lkc_pkg::CAP_W-1:0] cfg_data
);

  lkc_pkg::ctl_t ctl;
  lkc_pkg::sts_t sts;

  lkc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  lkc_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

endmodule

[design/lkc_checker.sv]
// port level checks of the lru key cache, bound to the top level
module lkc_assertions (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input lkc_pkg::out_item_t out_data
);

  // reset empties the result register and frees the input side
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result pending or input stalled after reset");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // one item at a time: the beat after an accepted one waits
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in the compare step");

  // a rising result is first sampled once its input beat has passed the compare and update steps
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 3))
    else $error("result beat without a matching input beat");

  // a result found flag and an insert never come together, and an eviction only comes with an insert
  a_found_xor_ins: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.found && out_data.inserted) &&
                  !(out_data.evicted && !out_data.inserted))
    else $error("inconsistent result flags");

endmodule

bind lru_key_cache lkc_assertions u_lkc_assertions (.*);
